### hw/rtl/olsup_pkg.sv
// Package: shared types, codes and reset constants for the oscillator lock supervisor.
`default_nettype none
package olsup_pkg;

  // Reset and default values
  localparam logic [14:0] PHASE_TOL_RST   = 15'd32;
  localparam logic [7:0]  QUALIFY_RST     = 8'd100;
  localparam logic [7:0]  START_DELAY_RST = 8'd15;
  localparam logic [15:0] DAC_DEFAULT     = 16'd23000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_TOL   = 2'd0,
    REG_QUALIFY     = 2'd1,
    REG_START_DELAY = 2'd2,
    REG_INIT_DAC    = 2'd3
  } cfg_reg_t;

  // Save strobe codes
  localparam logic [1:0] SAVE_NONE = 2'd0;
  localparam logic [1:0] SAVE_HIGH = 2'd1;
  localparam logic [1:0] SAVE_LOW  = 2'd2;

  // Input request
  typedef struct packed {
    logic signed [15:0] phase_diff;
    logic               reference_ok;
    logic [15:0]        dac_readback;
    logic [7:0]         time_valid_level;
  } in_req_t;

  // Result request
  typedef struct packed {
    logic        locked;
    logic        fast_filter;
    logic        holdover_mode;
    logic        oscillator_reset;
    logic        dac_write;
    logic [15:0] dac_write_value;
    logic [15:0] dac_average;
    logic [1:0]  save_strobe;
    logic [7:0]  save_byte;
  } out_req_t;

  // Configuration register set
  typedef struct packed {
    logic [14:0] phase_tolerance;
    logic [7:0]  qualify_count;
    logic [7:0]  start_delay;
  } cfg_t;

  // Supervisor state
  typedef struct packed {
    logic        lock_flag;
    logic [7:0]  qualify_counter;
    logic        fast_select;
    logic        fixed_select;
    logic        reset_hold;
    logic [15:0] dac_value;
    logic [15:0] dac_mean;
    logic [7:0]  start_counter;
  } sup_state_t;

  // Zero means never saved: fall back to the default control value
  function automatic logic [15:0] stored_or_default(input logic [15:0] v);
    return (v == 16'd0) ? DAC_DEFAULT : v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/olsup_step.sv
// One tick of the supervisor: next state and the result request.
`default_nettype none
module olsup_step
  import olsup_pkg::*;
(
  input  wire sup_state_t cur,
  input  wire cfg_t       cfg,
  input  wire in_req_t    req,
  output sup_state_t      nxt,
  output out_req_t        res
);

  logic signed [16:0] pd;
  logic signed [16:0] tol_pos;
  logic signed [16:0] tol_neg;
  logic               in_window;
  logic               outside;
  logic               ref_ok;
  logic               run_done;
  logic [7:0]         qc_inc;
  logic [7:0]         sc_inc;
  logic               tvalid;
  sup_state_t         s;

  always_comb begin
    pd        = {req.phase_diff[15], req.phase_diff};
    tol_pos   = {2'b00, cfg.phase_tolerance};
    tol_neg   = -tol_pos;
    in_window = (pd < tol_pos) && (pd > tol_neg);
    outside   = (pd > tol_pos) || (pd < tol_neg);
    ref_ok    = req.reference_ok;
    run_done  = cur.qualify_counter > cfg.qualify_count;
    qc_inc    = cur.qualify_counter + 8'd1;
    sc_inc    = cur.start_counter + 8'd1;
    tvalid    = req.time_valid_level > 8'd1;
    s         = cur;
    res       = '0;

    // Lock qualification / unlock run
    if (!cur.lock_flag && ref_ok) begin
      if (in_window) begin
        if (run_done) begin
          s.qualify_counter = '0;
          s.lock_flag       = 1'b1;
          s.fast_select     = 1'b0;
        end else begin
          s.qualify_counter = qc_inc;
        end
      end else begin
        s.qualify_counter = '0;
      end
    end else if (cur.lock_flag) begin
      if (outside) begin
        if (run_done) begin
          s.qualify_counter = '0;
          s.lock_flag       = 1'b0;
          s.fast_select     = 1'b1;
        end else begin
          s.qualify_counter = qc_inc;
        end
      end else begin
        s.qualify_counter = '0;
      end
    end else begin
      s.qualify_counter = '0;
    end

    // Holdover entry and exit
    if (!ref_ok && !cur.fixed_select) begin
      res.dac_write       = 1'b1;
      res.dac_write_value = cur.dac_value;
      s.fixed_select      = 1'b1;
      s.lock_flag         = 1'b0;
    end else if (ref_ok && cur.fixed_select) begin
      s.fixed_select = 1'b0;
    end

    // DAC tracking and byte saves while locked
    if (s.lock_flag && ref_ok) begin
      s.dac_value = req.dac_readback;
      s.dac_mean  = cur.dac_mean - {4'd0, cur.dac_mean[15:4]}
                    + {4'd0, req.dac_readback[15:4]};
      if (cur.start_counter == 8'd1) begin
        res.save_strobe = SAVE_HIGH;
        res.save_byte   = req.dac_readback[15:8];
      end else if (cur.start_counter == 8'd2) begin
        res.save_strobe = SAVE_LOW;
        res.save_byte   = req.dac_readback[7:0];
      end
    end

    // Start delay for the oscillator reset
    if (tvalid && ref_ok) begin
      s.start_counter = sc_inc;
      if (sc_inc == cfg.start_delay) begin
        s.reset_hold = 1'b0;
      end
    end else begin
      s.start_counter = '0;
    end

    res.locked           = s.lock_flag;
    res.fast_filter      = s.fast_select;
    res.holdover_mode    = s.fixed_select;
    res.oscillator_reset = s.reset_hold;
    res.dac_average      = s.dac_mean;
    nxt                  = s;
  end

endmodule
`default_nettype wire

### hw/rtl/oscillator_lock_supervisor_core.sv
// Top level of the oscillator lock supervisor: registers, handshake and configuration.
// One request per clock is accepted while the result is not stalled, and one result
// comes out per request. A request lands in the input register when it is accepted;
// the result register then loads the tick result, and the state takes the tick update,
// when the result slot is free or being drained; a stalled result holds the input
// register and so stalls the input. Configuration writes (cfg_wr_en) are meant
// for idle periods; writing initial_dac also reloads the stored DAC value (zero
// selects 23000).
`default_nettype none
module oscillator_lock_supervisor_core
  import olsup_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_stall,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire          out_stall,
  output out_req_t     out_data,
  input  wire          cfg_wr_en,
  input  wire [1:0]    cfg_index,
  input  wire [15:0]   cfg_data
);

  cfg_t       cfg_r;
  sup_state_t st_r;
  sup_state_t st_nxt;
  in_req_t    in_q_r;
  logic       in_q_vld_r;
  out_req_t   res_nxt;
  logic       advance;
  logic       take_in;

  // Tick update logic
  olsup_step u_step (
    .cur (st_r),
    .cfg (cfg_r),
    .req (in_q_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  // Handshake: stage moves when the result slot is free or being drained
  assign advance  = in_q_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_q_vld_r && !advance;
  assign take_in  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_vld_r <= 1'b0;
    end else if (take_in) begin
      in_q_vld_r <= 1'b1;
    end else if (advance) begin
      in_q_vld_r <= 1'b0;
    end
    if (take_in) begin
      in_q_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= res_nxt;
    end
  end

  // Configuration registers and supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_tolerance <= PHASE_TOL_RST;
      cfg_r.qualify_count   <= QUALIFY_RST;
      cfg_r.start_delay     <= START_DELAY_RST;
      st_r.lock_flag        <= 1'b0;
      st_r.qualify_counter  <= '0;
      st_r.fast_select      <= 1'b1;
      st_r.fixed_select     <= 1'b0;
      st_r.reset_hold       <= 1'b1;
      st_r.dac_value        <= DAC_DEFAULT;
      st_r.dac_mean         <= '0;
      st_r.start_counter    <= '0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PHASE_TOL:   cfg_r.phase_tolerance <= cfg_data[14:0];
          REG_QUALIFY:     cfg_r.qualify_count   <= cfg_data[7:0];
          REG_START_DELAY: cfg_r.start_delay     <= cfg_data[7:0];
          REG_INIT_DAC:    st_r.dac_value        <= stored_or_default(cfg_data);
          default:         ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/olsup_checker.sv
// Port-level checker for the oscillator lock supervisor, bound to the top level.
`default_nettype none
module olsup_checker
  import olsup_pkg::*;
(
  input wire           clk,
  input wire           rst_n,
  input wire           out_valid,
  input wire           out_stall,
  input wire out_req_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Lock and holdover never show together
  a_lock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.locked && out_data.holdover_mode))
    else $error("locked while in holdover");

  // Lock always runs on the slow filter
  a_lock_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.locked |-> !out_data.fast_filter)
    else $error("locked with fast filter");

  // A holdover write comes with holdover mode; idle fields stay zero
  a_dac_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dac_write && out_data.holdover_mode)
                  || (!out_data.dac_write && out_data.dac_write_value == 16'd0))
    else $error("bad holdover write");

  // Save strobe is a legal code and the byte is zero without a strobe
  a_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.save_strobe == SAVE_HIGH || out_data.save_strobe == SAVE_LOW)
                  || (out_data.save_strobe == SAVE_NONE && out_data.save_byte == 8'd0))
    else $error("bad save strobe");

endmodule

bind oscillator_lock_supervisor_core olsup_checker u_olsup_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
